### src/grs_pkg.sv
// shared types and constants for the group reverse stream block
`default_nettype none

package grs_pkg;

    localparam int VALUE_W         = 32;
    localparam int CFG_W           = 5;
    // widest group store the block is built for
    localparam int MAX_GROUP_LIMIT = 64;
    localparam int CNT_W           = $clog2(MAX_GROUP_LIMIT + 1);

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CFG_W-1:0]          t_cfg;
    typedef logic [CNT_W-1:0]          t_count;

    localparam t_cfg CFG_RESET = t_cfg'(1);

    // one closed group, handed from the front to the back
    typedef struct packed {
        logic   bank;
        t_count count;
        logic   reverse;
        logic   eol;
    } t_cmd;

    // back gives a bank back to the front once every entry has been read
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    // one result waiting in the output queue
    typedef struct packed {
        t_value value;
        logic   last;
        logic   done;
    } t_res;

endpackage

`default_nettype wire

### src/grs_in_if.sv
// input stream channel: value with end-of-list mark
`default_nettype none

interface grs_in_if import grs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value;
    logic   end_of_list;

    modport source (output valid, output value, output end_of_list, input ready);
    modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

`default_nettype wire

### src/grs_out_if.sv
// output stream channel: reordered value with run and list marks
`default_nettype none

interface grs_out_if import grs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value_res;
    logic   last_of_run;
    logic   list_done;

    modport source (output valid, output value_res, output last_of_run, output list_done,
                    input ready);
    modport sink   (input valid, input value_res, input last_of_run, input list_done,
                    output ready);
endinterface

`default_nettype wire

### src/group_reverse_stream_top.sv
// top level of the group reverse stream block
`default_nettype none

// group reverse stream: takes signed 32-bit values with an end-of-list mark and
// gives them back in groups of k (register group_size, reset 1). A full group of
// k values leaves in reverse order; a shorter group closed by the end mark leaves
// in its original order; k of 0 or 1 passes every value through, and k above
// MAX_GROUP counts as MAX_GROUP. last_of_run marks the final result caused by an
// input, list_done the final result of the list. Lowering k while values are held
// makes the next input close the group reversed once the held count reaches k.
// Rate: the front takes one item per cycle into a two-bank store; the back reads
// the single read port of that store and sends one result per cycle while the
// output is ready, so on average one item per cycle goes through. The front
// stalls only when the bank it would fill is still being drained. A closing
// transfer reaches the output through the command queue, the registered store
// read and an output slot. Change group_size only while the block is idle.
module group_reverse_stream_top import grs_pkg::*; #(
    parameter int MAX_GROUP = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    grs_in_if.sink    i_in,
    grs_out_if.source o_out,
    input  wire logic i_cfg_wr_en,
    input  wire t_cfg i_cfg_wr_data
);

    localparam int ADDR_W = $clog2(MAX_GROUP) + 1;

    // closed groups from front to back
    logic     cmd_push;
    t_cmd     cmd_in;
    logic     cmd_pop;
    logic     cmd_valid;
    logic     cmd_full;
    t_cmd     cmd_head;
    // bank handed back when drained
    t_release release_bank;

    // store ports: front writes one bank while the back reads the other
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_value            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_value            rd_data;

    grs_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (cmd_full),
        .i_release     (release_bank),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    grs_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_full  (cmd_full),
        .o_cmd   (cmd_head)
    );

    // two banks, each padded to a power of two, bank select is the top address bit
    grs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (2 ** ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    grs_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_release   (release_bank),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    // the front never closes a group into a full command queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("group closed while command queue full");

    // the back only gives back a bank while it works on a queued group
    a_release_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_bank.valid |-> (cmd_valid && cmd_pop))
        else $error("bank released without a group at the queue head");

    // reads never touch the bank the front is writing in the same cycle
    a_bank_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr[ADDR_W-1] != rd_addr[ADDR_W-1]))
        else $error("store read and write hit the same bank");

    // end of list only on the last result of a run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.list_done) |-> o_out.last_of_run)
        else $error("list_done without last_of_run");
`endif

endmodule

`default_nettype wire

### src/grs_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module grs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/grs_front.sv
// front: takes items, fills the ping-pong store, closes groups
`default_nettype none

module grs_front import grs_pkg::*; #(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    grs_in_if.sink                              i_in,
    input  wire logic                           i_cfg_wr_en,
    input  wire t_cfg                           i_cfg_wr_data,
    input  wire logic                           i_q_full,
    input  wire t_release                       i_release,
    output logic                                o_cmd_push,
    output t_cmd                                o_cmd,
    output logic                                o_wr_en,
    output logic [$clog2(MAX_GROUP):0]          o_wr_addr,
    output t_value                              o_wr_data
);

    localparam int IDX_W  = $clog2(MAX_GROUP);
    localparam int FILL_W = $clog2(MAX_GROUP + 1);
    localparam int KCMP_W = (CFG_W > FILL_W) ? CFG_W : FILL_W;

    t_cfg             r_cfg;
    logic             r_bank, n_bank;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic [1:0]       r_busy, n_busy;

    logic [KCMP_W-1:0] k_eff;
    logic [KCMP_W-1:0] count;
    logic              full_grp;
    logic              flush;
    logic              accept;

    // effective group size: saturate above the store size, zero acts as one
    always_comb begin
        if (KCMP_W'(r_cfg) > KCMP_W'(MAX_GROUP)) begin
            k_eff = KCMP_W'(MAX_GROUP);
        end else if (r_cfg == '0) begin
            k_eff = KCMP_W'(1);
        end else begin
            k_eff = KCMP_W'(r_cfg);
        end
    end

    assign count    = KCMP_W'(r_fill) + KCMP_W'(1);
    assign full_grp = (count >= k_eff);
    assign flush    = full_grp || i_in.end_of_list;

    assign i_in.ready = !r_busy[r_bank] && !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    assign o_wr_en   = accept;
    assign o_wr_addr = {r_bank, r_fill};
    assign o_wr_data = i_in.value;

    assign o_cmd_push    = accept && flush;
    assign o_cmd.bank    = r_bank;
    assign o_cmd.count   = CNT_W'(count);
    assign o_cmd.reverse = full_grp;
    assign o_cmd.eol     = i_in.end_of_list;

    always_comb begin
        n_bank = r_bank;
        n_fill = r_fill;
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept) begin
            if (flush) begin
                n_busy[r_bank] = 1'b1;
                n_bank         = !r_bank;
                n_fill         = '0;
            end else begin
                n_fill = r_fill + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_RESET;
            r_bank <= 1'b0;
            r_fill <= '0;
            r_busy <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            r_bank <= n_bank;
            r_fill <= n_fill;
            r_busy <= n_busy;
        end
    end

endmodule

`default_nettype wire

### src/grs_cmd_queue.sv
// two-entry queue of closed groups between front and back
`default_nettype none

module grs_cmd_queue import grs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_cmd      o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_cmd   = r_slot[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = !r_wp;
        end
        if (i_pop) begin
            n_rp = !r_rp;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### src/grs_back.sv
// back: drains a closed group from the store, one result per cycle while the output is ready
`default_nettype none

module grs_back import grs_pkg::*; #(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  wire t_cmd                  i_cmd,
    output logic                       o_cmd_pop,
    output t_release                   o_release,
    output logic                       o_rd_en,
    output logic [$clog2(MAX_GROUP):0] o_rd_addr,
    input  wire t_value                i_rd_data,
    grs_out_if.source                  o_out
);

    localparam int IDX_W  = $clog2(MAX_GROUP);
    localparam int FILL_W = $clog2(MAX_GROUP + 1);

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_inflight;
    logic              r_tag_last;
    logic              r_tag_done;
    t_res              r_res [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_occ, n_occ;

    logic [FILL_W-1:0] cnt;
    logic [FILL_W-1:0] rev_pos;
    logic [IDX_W-1:0]  rd_idx;
    logic              last;
    logic              pop;
    logic              issue;
    t_res              res_in;

    assign cnt     = FILL_W'(i_cmd.count);
    assign last    = (FILL_W'(r_idx) + FILL_W'(1) == cnt);
    assign rev_pos = cnt - FILL_W'(1) - FILL_W'(r_idx);
    assign rd_idx  = i_cmd.reverse ? rev_pos[IDX_W-1:0] : r_idx;

    assign pop   = o_out.valid && o_out.ready;
    // keep queued plus in-flight results within the two output slots
    assign issue = i_cmd_valid && (((r_occ + 2'(r_inflight)) < 2'd2) || pop);

    assign o_rd_en         = issue;
    assign o_rd_addr       = {i_cmd.bank, rd_idx};
    assign o_cmd_pop       = issue && last;
    assign o_release.valid = issue && last;
    assign o_release.bank  = i_cmd.bank;

    assign res_in.value = i_rd_data;
    assign res_in.last  = r_tag_last;
    assign res_in.done  = r_tag_done;

    assign o_out.valid       = (r_occ != 2'd0);
    assign o_out.value_res   = r_res[r_rp].value;
    assign o_out.last_of_run = r_res[r_rp].last;
    assign o_out.list_done   = r_res[r_rp].done;

    always_comb begin
        n_idx = r_idx;
        if (issue) begin
            n_idx = last ? '0 : r_idx + IDX_W'(1);
        end
        n_occ = r_occ + 2'(r_inflight) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        r_tag_last <= last;
        r_tag_done <= last && i_cmd.eol;
        if (r_inflight) begin
            r_res[r_wp] <= res_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_inflight <= 1'b0;
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_occ      <= '0;
        end else begin
            r_idx      <= n_idx;
            r_inflight <= issue;
            r_occ      <= n_occ;
            if (r_inflight) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
    end

endmodule

`default_nettype wire

### verif/group_reverse_stream_top_tb.sv
// self-checking testbench for the group reverse stream block
`default_nettype none

module group_reverse_stream_top_tb;
    import grs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GROUP    = 16;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    // first result passes the queue, the store read and an output slot; keep a margin
    localparam int SETTLE_CYCLES = 8;
    localparam int TARGET_ITEMS  = 300;
    // watchdog limit, well above the slowest legal run
    localparam int RUN_LIMIT_NS  = 10_000_000;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } t_row_kind;

    // one line of the directed sequence: a register write or an input transfer,
    // optionally with the single result it must cause typed in by hand
    typedef struct packed {
        t_row_kind kind;
        t_cfg      size;
        t_value    value;
        logic      eol;
        logic      typed;
        t_res      want;
    } t_stim_row;

    localparam int N_ROWS = 29;

    localparam t_stim_row STIM_ROWS [0:N_ROWS-1] = '{
        // after reset k is 1: straight pass through, extremes of value
        '{ROW_ITEM, 5'd0,  32'sh7FFF_FFFF, 1'b0, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
        '{ROW_ITEM, 5'd0,  32'sh8000_0000, 1'b1, 1'b1, '{32'sh8000_0000, 1'b1, 1'b1}},
        // zero group size behaves as one
        '{ROW_CFG,  5'd0,  32'sh0,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh0000_0000, 1'b0, 1'b1, '{32'sh0000_0000, 1'b1, 1'b0}},
        '{ROW_ITEM, 5'd0,  32'shFFFF_FFFF, 1'b1, 1'b1, '{32'shFFFF_FFFF, 1'b1, 1'b1}},
        // oversized group saturates at MAX_GROUP, end mark lands on the full group
        '{ROW_CFG,  5'd31, 32'sh0,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'shA500_0000, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh5A00_0001, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'shA500_0002, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh5A00_0003, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'shA500_0004, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh5A00_0005, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'shA500_0006, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh5A00_0007, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'shA500_0008, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh5A00_0009, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'shA500_000A, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh5A00_000B, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'shA500_000C, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh5A00_000D, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'shA500_000E, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh5A00_000F, 1'b1, 1'b0, '0},
        // short trailing group closed by the end mark keeps its order
        '{ROW_CFG,  5'd4,  32'sh0,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh0000_1111, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh0000_2222, 1'b1, 1'b0, '0},
        // two values held, then k drops to the held count
        '{ROW_ITEM, 5'd0,  32'sh0000_3333, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh0000_4444, 1'b0, 1'b0, '0},
        '{ROW_CFG,  5'd2,  32'sh0,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 5'd0,  32'sh0000_5555, 1'b0, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    t_cfg i_cfg_wr_data;

    grs_in_if  in_ch ();
    grs_out_if out_ch ();

    group_reverse_stream_top #(
        .MAX_GROUP (MAX_GROUP)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // shadow of the block: register copy, held values and their count
    t_cfg        size_shadow;
    t_value      held_values [MAX_GROUP];
    int unsigned held_count;

    // results caused by the latest transfer, and all results still owed
    t_res run_results [$];
    t_res owed_results [$];

    int items_sent;
    int fail_count;
    int src_gap_pct;
    int sink_stall_pct;

    function automatic int unsigned effective_group(input t_cfg size);
        int unsigned k;
        k = (size > MAX_GROUP) ? MAX_GROUP : size;
        return (k == 0) ? 1 : k;
    endfunction

    // most gaps are short, a few are long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'shFFFF_FFFF;
            default: return t_value'($urandom);
        endcase
    endfunction

    // mostly small groups, sometimes the edges of the register range
    function automatic t_cfg pick_group_size();
        case ($urandom_range(0, 9))
            0: return t_cfg'(0);
            1: return t_cfg'(1);
            2: return t_cfg'(MAX_GROUP);
            3: return t_cfg'(31);
            4: return t_cfg'($urandom_range(MAX_GROUP + 1, 30));
            default: return t_cfg'($urandom_range(2, 8));
        endcase
    endfunction

    // store the value, then release a full group reversed or a closed short
    // group in order; fills run_results with what this transfer causes
    task automatic predict_reorder(input t_value v, input logic eol);
        int unsigned k;
        int unsigned n;
        logic        full;
        t_res        r;
        run_results.delete();
        k = effective_group(size_shadow);
        if (held_count < MAX_GROUP) begin
            held_values[held_count] = v;
            held_count++;
        end
        n    = held_count;
        full = (n >= k);
        if (full || eol) begin
            for (int i = 0; i < n; i++) begin
                r.value = full ? held_values[n - 1 - i] : held_values[i];
                r.last  = (i == n - 1);
                r.done  = r.last && eol;
                run_results.push_back(r);
            end
            held_count = 0;
        end
    endtask

    task automatic hold_input();
        in_ch.valid <= 1'b0;
    endtask

    // sender pauses until every owed result has left the block
    task automatic pause_for_results();
        hold_input();
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    // nothing owed, and enough extra cycles for values that cause no result
    task automatic wait_idle();
        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_group_size(input t_cfg size);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        size_shadow = size;
    endtask

    // one input transfer; valid stays high afterwards so that back-to-back
    // transfers never lower and raise it within the same step
    task automatic send_item(input t_value v, input logic eol, input logic typed,
                             input t_res typed_res);
        int gap;
        gap = pick_gap(src_gap_pct);
        if (gap > 0) begin
            hold_input();
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.value       <= v;
        in_ch.end_of_list <= eol;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_reorder(v, eol);
        if (typed) begin
            owed_results.push_back(typed_res);
        end else begin
            foreach (run_results[i]) owed_results.push_back(run_results[i]);
        end
        items_sent++;
    endtask

    // receiver: checks each output transfer against the oldest owed result
    // and stalls at random
    initial begin
        int   stall_left;
        t_res want;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected transfer: value_res %0d last_of_run %0b list_done %0b",
                           out_ch.value_res, out_ch.last_of_run, out_ch.list_done);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (out_ch.value_res !== want.value) begin
                        $error("value_res: expected %0d, actual %0d",
                               want.value, out_ch.value_res);
                        fail_count++;
                    end
                    if (out_ch.last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, out_ch.last_of_run);
                        fail_count++;
                    end
                    if (out_ch.list_done !== want.done) begin
                        $error("list_done: expected %0b, actual %0b",
                               want.done, out_ch.list_done);
                        fail_count++;
                    end
                end
            end
            if (stall_left == 0) stall_left = pick_gap(sink_stall_pct);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus: reset, directed rows, then random phases of lists
    initial begin
        int          phase_len;
        int          list_left;
        int unsigned k;
        logic        eol;

        fail_count     = 0;
        items_sent     = 0;
        src_gap_pct    = 15;
        sink_stall_pct = 15;
        size_shadow    = CFG_RESET;
        held_count     = 0;

        i_rst_n           <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_data     <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.value       <= '0;
        in_ch.end_of_list <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (STIM_ROWS[r]) begin
            if (STIM_ROWS[r].kind == ROW_CFG) begin
                write_group_size(STIM_ROWS[r].size);
            end else begin
                send_item(STIM_ROWS[r].value, STIM_ROWS[r].eol, STIM_ROWS[r].typed,
                          STIM_ROWS[r].want);
            end
        end

        // each phase may stop mid-list, so the next size can land on held values
        while (items_sent < TARGET_ITEMS) begin
            write_group_size(pick_group_size());
            src_gap_pct    = pick_pct();
            sink_stall_pct = pick_pct();
            k              = effective_group(size_shadow);
            phase_len      = $urandom_range(8, 40);
            list_left      = $urandom_range(1, 2 * k + 3);
            for (int n = 0; n < phase_len; n++) begin
                list_left--;
                // lists mostly end where planned, now and then early
                eol = (list_left == 0) || ($urandom_range(0, 39) == 0);
                if (eol) list_left = $urandom_range(1, 2 * k + 3);
                if ($urandom_range(0, 49) == 0) pause_for_results();
                send_item(pick_value(), eol, 1'b0, '0);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("group_reverse_stream_top_tb passed");
        end else begin
            $display("group_reverse_stream_top_tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #RUN_LIMIT_NS;
        $display("group_reverse_stream_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
